FILE: rtl/core/usi_pkg.sv
// Shared types and constants for the UART serial interface core.
package usi_pkg;

    // Item operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_RXB   = 2'd3;

    // Register selects
    localparam logic [1:0] SEL_CTRL   = 2'd0;
    localparam logic [1:0] SEL_TDR    = 2'd1;
    localparam logic [1:0] SEL_STATUS = 2'd2;
    localparam logic [1:0] SEL_RDR    = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEVEN_BIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_STOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_DIV   = 3'd4;

    // Interrupt source codes
    localparam logic [1:0] IRQ_NONE = 2'd0;
    localparam logic [1:0] IRQ_RXI  = 2'd1;
    localparam logic [1:0] IRQ_TXI  = 2'd2;
    localparam logic [1:0] IRQ_TEI  = 2'd3;

    // Status bits
    localparam logic [7:0] ST_TDRE = 8'h80;
    localparam logic [7:0] ST_RDRF = 8'h40;
    localparam logic [7:0] ST_ORER = 8'h20;
    localparam logic [7:0] ST_FER  = 8'h10;
    localparam logic [7:0] ST_PER  = 8'h08;
    localparam logic [7:0] ST_TEND = 8'h04;
    localparam logic [7:0] ST_MPBT = 8'h01;
    localparam logic [7:0] ST_ERRS = ST_RDRF | ST_ORER | ST_FER | ST_PER;

    // Control bits
    localparam logic [7:0] CT_TIE  = 8'h80;
    localparam logic [7:0] CT_RIE  = 8'h40;
    localparam logic [7:0] CT_TE   = 8'h20;
    localparam logic [7:0] CT_RE   = 8'h10;
    localparam logic [7:0] CT_TEIE = 8'h04;

    localparam logic [7:0] RX_MASK7 = 8'h7f;

    // Reset values
    localparam logic [7:0] STATUS_RST  = 8'h84;
    localparam logic [7:0] TXHOLD_RST  = 8'hff;
    localparam logic [7:0] BAUD_RST    = 8'hff;

    localparam int TIMER_W = 23;

    typedef struct packed {
        logic       seven_bit;
        logic       parity;
        logic       two_stop;
        logic [1:0] clock_sel;
        logic [7:0] baud_div;
    } usi_cfg_t;

    typedef struct packed {
        logic [7:0]         control;
        logic [7:0]         status;
        logic [7:0]         seen;
        logic [7:0]         tx_hold;
        logic [7:0]         rx_hold;
        logic [TIMER_W-1:0] tx_remaining;
    } usi_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } usi_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] irq_source;
    } usi_rsp_t;

endpackage

FILE: rtl/core/usi_step.sv
// Next-state and result logic for one request of the UART serial interface.
module usi_step import usi_pkg::*; (
    input  usi_cfg_t   cfg,
    input  usi_state_t cur,
    input  usi_req_t   req,
    output usi_state_t nxt,
    output usi_rsp_t   rsp
);

    logic [8:0]         base;
    logic [3:0]         shift;
    logic [3:0]         frame_bits;
    logic [19:0]        bit_time;
    logic [TIMER_W-1:0] frame_len;
    logic [7:0]         pend;

    // Frame length: bit time times start, data, parity and stop bits
    always_comb begin
        base       = {1'b0, cfg.baud_div} + 9'd1;
        shift      = {1'b0, cfg.clock_sel, 1'b0} + 4'd5;
        frame_bits = (cfg.seven_bit ? 4'd7 : 4'd8) + {3'd0, cfg.parity}
                   + (cfg.two_stop ? 4'd2 : 4'd1) + 4'd1;
        bit_time   = 20'(base) << shift;
        frame_len  = TIMER_W'(bit_time) * TIMER_W'(frame_bits);
    end

    always_comb begin
        nxt = cur;
        rsp = '0;
        case (req.operation)
            OP_TICK: begin
                if (cur.tx_remaining != '0) begin
                    nxt.tx_remaining = cur.tx_remaining - TIMER_W'(1);
                end
                if (nxt.tx_remaining == '0) begin
                    if ((cur.status & ST_TDRE) == '0) begin
                        nxt.status       = cur.status | ST_TDRE;
                        nxt.tx_remaining = frame_len;
                        if ((cur.control & CT_TE) != '0) begin
                            rsp.tx_valid = 1'b1;
                            rsp.tx_byte  = cur.tx_hold;
                        end
                    end else begin
                        nxt.status = cur.status | ST_TEND;
                    end
                end
            end
            OP_READ: begin
                case (req.reg_select)
                    SEL_CTRL:   rsp.read_data = cur.control;
                    SEL_TDR:    rsp.read_data = cur.tx_hold;
                    SEL_STATUS: begin
                        rsp.read_data = cur.status;
                        nxt.seen      = cur.status;
                    end
                    default:    rsp.read_data = cur.rx_hold;
                endcase
            end
            OP_WRITE: begin
                case (req.reg_select)
                    SEL_CTRL: nxt.control = req.write_data;
                    SEL_TDR:  nxt.tx_hold = req.write_data;
                    SEL_STATUS: begin
                        // Clearing TDRE after seeing it set queues the byte
                        if ((cur.seen & ~req.write_data & ST_TDRE) != '0) begin
                            nxt.status = cur.status & ~(ST_TDRE | ST_TEND);
                            if (cur.tx_remaining == '0) begin
                                nxt.status       = nxt.status | ST_TDRE;
                                nxt.tx_remaining = frame_len;
                                if ((cur.control & CT_TE) != '0) begin
                                    rsp.tx_valid = 1'b1;
                                    rsp.tx_byte  = cur.tx_hold;
                                end
                            end
                        end
                        // Flags clear only where seen as 1 and written as 0
                        nxt.status = nxt.status & ~(cur.seen & ~req.write_data & ST_ERRS);
                        nxt.status = (nxt.status & ~ST_MPBT) | (req.write_data & ST_MPBT);
                    end
                    default: ;
                endcase
            end
            default: begin
                if ((cur.control & CT_RE) != '0) begin
                    if ((cur.status & ST_RDRF) != '0) begin
                        nxt.status = cur.status | ST_ORER;
                    end else begin
                        nxt.rx_hold = cfg.seven_bit ? (req.rx_byte & RX_MASK7) : req.rx_byte;
                        nxt.status  = cur.status | ST_RDRF;
                    end
                end
            end
        endcase

        pend = nxt.control & nxt.status & (ST_RDRF | ST_TDRE | ST_TEND);
        if ((pend & ST_RDRF) != '0) begin
            rsp.irq_source = IRQ_RXI;
        end else if ((pend & ST_TDRE) != '0) begin
            rsp.irq_source = IRQ_TXI;
        end else if ((pend & ST_TEND) != '0) begin
            rsp.irq_source = IRQ_TEI;
        end else begin
            rsp.irq_source = IRQ_NONE;
        end
    end

endmodule

FILE: rtl/core/uart_serial_interface_core.sv
// Top level of the UART serial interface core: request channel, result channel, config port.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready): operation selects a clock tick,
//   a register read, a register write or a byte received from the line. Each request
//   produces exactly one result on the m_ channel: read data, a transmitted byte
//   flagged by m_tx_valid, and the highest priority pending interrupt source.
//   A request accepted at one edge has its result in the output register after that
//   edge. Throughput is one request per cycle while the receiver takes each result;
//   the state update is a single pass through the step logic, and the frame length
//   is a shift of the divisor plus one times a small bit count.
//   When the receiver stalls (m_ready low with a result waiting), s_ready drops and
//   the held result stays; s_ready is high again in the cycle m_ready takes it.
//   The config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
//   sets character length, parity, stop bits, clock select and baud divisor; write
//   it only while no request is in flight. Indexes beyond the list are dropped.
//   Reset (aresetn low, synchronous) empties the output register and restores the
//   registers: status 0x84, transmit data 0xff, divisor 255, timer idle.
module uart_serial_interface_core import usi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [1:0]           s_reg_select,
    input  logic [7:0]           s_write_data,
    input  logic [7:0]           s_rx_byte,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_read_data,
    output logic                 m_tx_valid,
    output logic [7:0]           m_tx_byte,
    output logic [1:0]           m_irq_source,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    usi_cfg_t   cfg_reg;
    usi_state_t state_reg;
    usi_state_t state_next;
    usi_req_t   req;
    usi_rsp_t   rsp_next;
    usi_rsp_t   rsp_reg;
    logic       m_valid_reg;
    logic       s_accept;

    // Take a new request whenever the output register is empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign req.operation  = s_operation;
    assign req.reg_select = s_reg_select;
    assign req.write_data = s_write_data;
    assign req.rx_byte    = s_rx_byte;

    usi_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .req (req),
        .nxt (state_next),
        .rsp (rsp_next)
    );

    // Configuration registers: write the addressed field, drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seven_bit <= 1'b0;
            cfg_reg.parity    <= 1'b0;
            cfg_reg.two_stop  <= 1'b0;
            cfg_reg.clock_sel <= 2'd0;
            cfg_reg.baud_div  <= BAUD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SEVEN_BIT: cfg_reg.seven_bit <= cfg_data[0];
                CFG_PARITY:    cfg_reg.parity    <= cfg_data[0];
                CFG_TWO_STOP:  cfg_reg.two_stop  <= cfg_data[0];
                CFG_CLOCK_SEL: cfg_reg.clock_sel <= cfg_data[1:0];
                CFG_BAUD_DIV:  cfg_reg.baud_div  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Architectural state: advance only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.control      <= 8'h00;
            state_reg.status       <= STATUS_RST;
            state_reg.seen         <= STATUS_RST;
            state_reg.tx_hold      <= TXHOLD_RST;
            state_reg.rx_hold      <= 8'h00;
            state_reg.tx_remaining <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register: load on accept, clear valid once the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; hold it while stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = rsp_reg.read_data;
    assign m_tx_valid   = rsp_reg.tx_valid;
    assign m_tx_byte    = rsp_reg.tx_byte;
    assign m_irq_source = rsp_reg.irq_source;

endmodule

FILE: rtl/core/usi_checker.sv
// Port-level assertions for the UART serial interface core, bound to the top level.
module usi_port_checker import usi_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_operation,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_tx_byte))
        else $error("stalled result changed");

    // Reset empties the output register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every accepted request gives a result; only reads return data
    a_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation != OP_READ |=> m_valid && m_read_data == 8'h00)
        else $error("read data on a non-read request");

    // Reads and received bytes never transmit
    a_notx: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == OP_READ || s_operation == OP_RXB)
        |=> !m_tx_valid)
        else $error("transmit on read or receive request");

    // Transmit byte is zero when nothing was sent
    a_txbyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_byte == 8'h00)
        else $error("transmit byte without transmit");

endmodule

bind uart_serial_interface_core usi_port_checker u_usi_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_tx_valid  (m_tx_valid),
    .m_tx_byte   (m_tx_byte)
);
